// File: src/cbm_pkg.sv
// Shared types and constants of the cartridge bank mapper.
package cbm_pkg;

   // Item kinds on the request channel
   localparam logic [1:0] OP_LATCH = 2'd0;
   localparam logic [1:0] OP_EXP   = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Expansion area decode
   localparam logic [14:0] EXP_MASK    = 15'h4160;
   localparam logic [14:0] DEC_IRQ_EN  = 15'h4120;
   localparam logic [14:0] DEC_SPECIAL = 15'h4020;

   // Latch mode field, latch bits 7..6
   localparam logic [1:0] MODE_8K  = 2'b00;
   localparam logic [1:0] MODE_16K = 2'b01;

   localparam int IRQ_BIT = 12;

   typedef struct packed {
      logic [7:0]  latch_value;
      logic [7:0]  special_bank;
      logic [7:0]  irq_enable;
      logic [15:0] cycle_counter;
      logic        irq_pending;
   } regs_type;

   typedef struct packed {
      logic [7:0] bank_8000;
      logic [7:0] bank_a000;
      logic [7:0] bank_c000;
      logic [7:0] bank_e000;
      logic [1:0] chr_bank;
      logic       mirroring;
      logic       irq_line;
   } result_type;

endpackage

// File: src/cbm_req_if.sv
// Request channel: latch writes, expansion writes and cycle ticks.
interface cbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [14:0] address;
   logic [7:0]  wdata;
   logic [7:0]  cycles;

   modport source (output valid, op, address, wdata, cycles, input ready);
   modport sink   (input valid, op, address, wdata, cycles, output ready);
endinterface

// File: src/cbm_rsp_if.sv
// Response channel: bank numbers, mirroring and interrupt level.
interface cbm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] bank_8000;
   logic [7:0] bank_a000;
   logic [7:0] bank_c000;
   logic [7:0] bank_e000;
   logic [1:0] chr_bank;
   logic       mirroring;
   logic       irq_line;

   modport source (output valid, bank_8000, bank_a000, bank_c000, bank_e000,
                   chr_bank, mirroring, irq_line, input ready);
   modport sink   (input valid, bank_8000, bank_a000, bank_c000, bank_e000,
                   chr_bank, mirroring, irq_line, output ready);
endinterface

// File: src/cartridge_bank_mapper_with_irq.sv
// Cartridge bank mapper with cycle-counting irq, top level.
//
// req_bus carries one beat per CPU event: a latch write (op 0), an
// expansion-area write (op 1, decoded by address & 0x4160) or a cycle
// tick (op 2, adds cycles to the counter while enable bit 0 is set).
// Every accepted beat returns exactly one rsp_bus beat holding the four
// 8KB PRG bank numbers, the CHR bank, mirroring and the irq level as
// they stand after that beat's state update.
// The state update and bank decode sit between the request handshake
// and the response register, so a beat is valid the cycle after it is
// accepted. Throughput is one beat per cycle; req_bus.ready stays high
// while the response register is empty or drained in the same cycle.
// When the receiver stalls, the response register holds its beat and
// one more request is blocked until it is taken.
// Synchronous reset clears the latch, special bank, enable, counter and
// irq, and empties the response register.
module cartridge_bank_mapper_with_irq (
   input  logic      clock,
   input  logic      reset,
   cbm_req_if.sink   req_bus,
   cbm_rsp_if.source rsp_bus
);

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   cbm_pkg::result_type rsp_data_ff;
   cbm_pkg::result_type result;
   cbm_pkg::regs_type   state_next;
   logic                accept;

   assign req_bus.ready = ~rsp_valid_ff | rsp_bus.ready;
   assign accept        = req_bus.valid & req_bus.ready;

   cbm_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .op         (req_bus.op),
      .address    (req_bus.address),
      .wdata      (req_bus.wdata),
      .cycles     (req_bus.cycles),
      .state_next (state_next)
   );

   cbm_bank_map u_bank_map (
      .state  (state_next),
      .result (result)
   );

   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.bank_8000 = rsp_data_ff.bank_8000;
   assign rsp_bus.bank_a000 = rsp_data_ff.bank_a000;
   assign rsp_bus.bank_c000 = rsp_data_ff.bank_c000;
   assign rsp_bus.bank_e000 = rsp_data_ff.bank_e000;
   assign rsp_bus.chr_bank  = rsp_data_ff.chr_bank;
   assign rsp_bus.mirroring = rsp_data_ff.mirroring;
   assign rsp_bus.irq_line  = rsp_data_ff.irq_line;

endmodule

// File: src/cbm_regs.sv
// Mapper state registers: latch, expansion registers, cycle counter and irq.
module cbm_regs (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        op,
   input  logic [14:0]       address,
   input  logic [7:0]        wdata,
   input  logic [7:0]        cycles,
   output cbm_pkg::regs_type state_next
);

   cbm_pkg::regs_type state_ff;
   cbm_pkg::regs_type state_in;
   logic [14:0]       sel;
   logic [15:0]       count_sum;

   assign sel       = address & cbm_pkg::EXP_MASK;
   assign count_sum = state_ff.cycle_counter + {8'd0, cycles};

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         case (op)
            cbm_pkg::OP_LATCH: begin
               state_in.latch_value = wdata;
            end
            cbm_pkg::OP_EXP: begin
               if (sel == cbm_pkg::DEC_IRQ_EN) begin
                  state_in.irq_enable = wdata;
                  if (wdata == 8'd0) begin
                     state_in.cycle_counter = 16'd0;
                     state_in.irq_pending   = 1'b0;
                  end
               end else if (sel == cbm_pkg::DEC_SPECIAL) begin
                  state_in.special_bank = wdata;
               end
            end
            cbm_pkg::OP_TICK: begin
               if (state_ff.irq_enable[0]) begin
                  state_in.cycle_counter = count_sum;
                  // sticky: only a zero enable write or a reset drops it
                  if (count_sum[cbm_pkg::IRQ_BIT]) begin
                     state_in.irq_pending = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state_next = state_in;

endmodule

// File: src/cbm_bank_map.sv
// PRG/CHR bank decode from the latch and special bank register.
module cbm_bank_map (
   input  cbm_pkg::regs_type   state,
   output cbm_pkg::result_type result
);

   logic [7:0] d;
   logic [7:0] s;
   logic [2:0] b;
   logic [7:0] b2;
   logic [7:0] base;

   assign d    = state.latch_value;
   assign s    = state.special_bank;
   assign b    = {d[3], d[7], d[5]};
   assign b2   = {4'd0, b, 1'b0};
   assign base = {4'd0, b[2:1], 2'b00};

   always_comb begin
      result.chr_bank  = d[2:1];
      result.mirroring = ~d[2];
      result.irq_line  = state.irq_pending;
      if (d[3]) begin
         case (d[7:6])
            cbm_pkg::MODE_8K: begin
               result.bank_8000 = b2;
               result.bank_a000 = b2;
               result.bank_c000 = b2;
               result.bank_e000 = b2;
            end
            cbm_pkg::MODE_16K: begin
               result.bank_8000 = b2;
               result.bank_a000 = b2 | 8'd1;
               result.bank_c000 = b2;
               result.bank_e000 = b2 | 8'd1;
            end
            default: begin
               // 32KB: four consecutive banks
               result.bank_8000 = base;
               result.bank_a000 = base | 8'd1;
               result.bank_c000 = base | 8'd2;
               result.bank_e000 = base | 8'd3;
            end
         endcase
      end else begin
         // fixed layout, 0xC000 from the bit-shuffled special bank
         result.bank_8000 = 8'd0;
         result.bank_a000 = 8'd1;
         result.bank_c000 = {s[7:3], s[0], s[2:1]};
         result.bank_e000 = 8'd3;
      end
   end

endmodule
